// ===== sv/gmc_pkg.sv =====
package gmc_pkg;

  localparam int CNT_W     = 9;
  localparam int COL_W     = 5;
  localparam int VIS_W     = 7;
  localparam int OP_W      = 3;
  localparam int TGT_W     = 9;
  localparam int IDX_W     = 10;
  localparam int ROW_W     = 9;
  localparam int ARITH_W   = 14;
  localparam int VC_W      = COL_W + VIS_W;
  localparam int DVD_W     = 10;
  localparam int DVS_W     = COL_W;
  localparam int EV_W      = 2;
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;
  localparam int OUT_IDX_W = 9;
  localparam int OUT_TOP_W = 8;
  localparam int OUT_ROW_W = 8;
  localparam int OUT_COL_W = 4;

  localparam int DEF_MAX_ITEMS   = 256;
  localparam int DEF_MAX_COLS    = 16;
  localparam int DEF_MAX_VISIBLE = 64;

  localparam logic signed [IDX_W-1:0] IDX_NONE = '1;

  typedef enum logic [OP_W-1:0] {
    OP_SET,
    OP_DOWN,
    OP_UP,
    OP_RIGHT,
    OP_LEFT,
    OP_PAGE_DOWN,
    OP_PAGE_UP,
    OP_REFRESH
  } op_e;

  typedef enum logic [1:0] {
    REG_ITEM_COUNT,
    REG_COLUMN_COUNT,
    REG_VISIBLE_ROWS
  } reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LR_START,
    ST_LR_WAIT,
    ST_RC_START,
    ST_RC_WAIT,
    ST_OP,
    ST_PUT,
    ST_PRC_START,
    ST_PRC_WAIT,
    ST_PKV,
    ST_WRAP2,
    ST_FINAL,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [CNT_W-1:0] n_items;
    logic [COL_W-1:0] n_cols;
    logic [VIS_W-1:0] n_vis;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quot;
    logic [DVS_W-1:0] rem;
  } div_res_t;

endpackage

// ===== sv/gmc_regs.sv =====
module gmc_regs
  import gmc_pkg::*;
#(
  parameter int MAX_ITEMS   = DEF_MAX_ITEMS,
  parameter int MAX_COLS    = DEF_MAX_COLS,
  parameter int MAX_VISIBLE = DEF_MAX_VISIBLE
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output cfg_t              cfg_o
);

  logic [CNT_W-1:0] item_count_q;
  logic [COL_W-1:0] column_count_q;
  logic [VIS_W-1:0] visible_rows_q;
  logic             wr_en;
  reg_e             reg_sel;

  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = reg_e'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_count_q   <= '0;
      column_count_q <= COL_W'(1);
      visible_rows_q <= VIS_W'(1);
    end else if (wr_en) begin
      case (reg_sel)
        REG_ITEM_COUNT:   item_count_q   <= pwdata[CNT_W-1:0];
        REG_COLUMN_COUNT: column_count_q <= pwdata[COL_W-1:0];
        REG_VISIBLE_ROWS: visible_rows_q <= pwdata[VIS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_ITEM_COUNT:   prdata = DATA_W'(item_count_q);
      REG_COLUMN_COUNT: prdata = DATA_W'(column_count_q);
      REG_VISIBLE_ROWS: prdata = DATA_W'(visible_rows_q);
      default:          prdata = '0;
    endcase
  end

  always_comb begin
    if (int'(item_count_q) > MAX_ITEMS) begin
      cfg_o.n_items = CNT_W'(MAX_ITEMS);
    end else begin
      cfg_o.n_items = item_count_q;
    end
    if (column_count_q == '0) begin
      cfg_o.n_cols = COL_W'(1);
    end else if (int'(column_count_q) > MAX_COLS) begin
      cfg_o.n_cols = COL_W'(MAX_COLS);
    end else begin
      cfg_o.n_cols = column_count_q;
    end
    if (visible_rows_q == '0) begin
      cfg_o.n_vis = VIS_W'(1);
    end else if (int'(visible_rows_q) > MAX_VISIBLE) begin
      cfg_o.n_vis = VIS_W'(MAX_VISIBLE);
    end else begin
      cfg_o.n_vis = visible_rows_q;
    end
  end

endmodule

// ===== sv/gmc_div.sv =====
module gmc_div
  import gmc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_res_t res_o
);

  localparam int STEP_W = $clog2(DVD_W + 1);

  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] step_q;
  logic [DVD_W-1:0]  quo_q;
  logic [DVD_W-1:0]  quo_d;
  logic [DVS_W-1:0]  rem_q;
  logic [DVS_W-1:0]  rem_d;
  logic [DVS_W-1:0]  dvs_q;
  logic [DVS_W:0]    shift_w;
  logic              fits_w;

  // One quotient bit per cycle, restoring form.
  always_comb begin
    shift_w = {rem_q, quo_q[DVD_W-1]};
    fits_w  = shift_w >= {1'b0, dvs_q};
    if (fits_w) begin
      rem_d = DVS_W'(shift_w - {1'b0, dvs_q});
    end else begin
      rem_d = DVS_W'(shift_w);
    end
    quo_d = {quo_q[DVD_W-2:0], fits_w};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= STEP_W'(DVD_W);
      end else if (busy_q) begin
        step_q <= step_q - STEP_W'(1);
        if (step_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign res_o.done = done_q;
  assign res_o.quot = quo_q;
  assign res_o.rem  = rem_q;

endmodule

// ===== sv/grid_menu_cursor.sv =====
// Each input beat runs two divider passes, for the last row and for the cursor row and
// column, then one more divider pass per index update; a wrap to the start of a row adds
// another index update. Items are taken one at a time; the next item is taken once the
// result sits in the output register, and a stalled result holds the next item at its
// final state. Reset (asynchronous, active low): no selection, top row zero, list marked
// empty, item count 0, column count 1, visible rows 1, output empty.
module grid_menu_cursor
  import gmc_pkg::*;
#(
  parameter int MAX_ITEMS   = DEF_MAX_ITEMS,
  parameter int MAX_COLS    = DEF_MAX_COLS,
  parameter int MAX_VISIBLE = DEF_MAX_VISIBLE
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ADDR_W-1:0]           paddr,
  input  logic [DATA_W-1:0]           pwdata,
  output logic [DATA_W-1:0]           prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [OP_W-1:0]             operation_i,
  input  logic                        wrap_i,
  input  logic signed [TGT_W-1:0]     target_index_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [OUT_IDX_W-1:0] cursor_now_o,
  output logic [OUT_TOP_W-1:0]        scroll_top_o,
  output logic [OUT_ROW_W-1:0]        cursor_row_o,
  output logic [OUT_COL_W-1:0]        cursor_col_o,
  output logic [EV_W-1:0]             select_events_o
);

  localparam logic signed [ARITH_W-1:0] ONE_S  = ARITH_W'(1);
  localparam logic signed [ARITH_W-1:0] ZERO_S = '0;
  localparam logic signed [ARITH_W-1:0] NONE_S = '1;

  cfg_t     cfg;
  div_req_t div_req;
  div_res_t div_res;

  state_e state_q, state_d;
  op_e    op_q, op_d;
  logic   wrap_q, wrap_d;
  logic signed [TGT_W-1:0]   tgt_q, tgt_d;
  logic signed [IDX_W-1:0]   idx_q, idx_d;
  logic [ROW_W-1:0]          top_q, top_d;
  logic                      lwe_q, lwe_d;
  logic [EV_W-1:0]           ev_q, ev_d;
  logic [ROW_W-1:0]          row_q, row_d;
  logic [DVS_W-1:0]          col_q, col_d;
  logic [ROW_W-1:0]          lr_q, lr_d;
  logic [ROW_W-1:0]          hi_q, hi_d;
  logic [VC_W-1:0]           vc_q, vc_d;
  logic signed [ARITH_W-1:0] put_q, put_d;
  logic                      stage2_q, stage2_d;

  logic                        out_valid_q, out_valid_d;
  logic signed [OUT_IDX_W-1:0] out_idx_q, out_idx_d;
  logic [OUT_TOP_W-1:0]        out_top_q, out_top_d;
  logic [OUT_ROW_W-1:0]        out_row_q, out_row_d;
  logic [OUT_COL_W-1:0]        out_col_q, out_col_d;
  logic [EV_W-1:0]             out_ev_q, out_ev_d;

  logic signed [ARITH_W-1:0] n_s, c_s, idx_s, row_s, col_s, lr_s, vc_s;
  logic signed [ARITH_W-1:0] rc_s, lim_s, lastc_s, prc_s, plim_s, plast_s;
  logic signed [ARITH_W-1:0] pdn_s, pup_s, hi_s, clamp_s, op_tgt;
  logic                      n_zero, c_one, fresh, out_free;
  logic                      op_put, op_wrap2, op_stage2;
  logic [ROW_W:0]            top_plus_v;
  logic [ROW_W-1:0]          row_m_v, kv_top;
  logic                      row_lo, row_hi;

  gmc_regs #(
    .MAX_ITEMS  (MAX_ITEMS),
    .MAX_COLS   (MAX_COLS),
    .MAX_VISIBLE(MAX_VISIBLE)
  ) u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .cfg_o  (cfg)
  );

  gmc_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .res_o (div_res)
  );

  assign pready     = 1'b1;
  assign in_ready_o = (state_q == ST_IDLE);
  assign out_free   = !out_valid_q || out_ready_i;

  assign n_s    = signed'(ARITH_W'(cfg.n_items));
  assign c_s    = signed'(ARITH_W'(cfg.n_cols));
  assign idx_s  = ARITH_W'(idx_q);
  assign row_s  = signed'(ARITH_W'(row_q));
  assign col_s  = signed'(ARITH_W'(col_q));
  assign lr_s   = signed'(ARITH_W'(lr_q));
  assign vc_s   = signed'(ARITH_W'(vc_q));
  assign n_zero = (cfg.n_items == '0);
  assign c_one  = (cfg.n_cols == COL_W'(1));
  assign fresh  = lwe_q && idx_q[IDX_W-1];

  // Start of the current row is index minus column; without a selection it is row zero.
  always_comb begin
    rc_s    = idx_q[IDX_W-1] ? ZERO_S : (idx_s - col_s);
    lim_s   = n_s - rc_s;
    lastc_s = ((c_s < lim_s) ? c_s : lim_s) - ONE_S;
    prc_s   = rc_s - c_s;
    plim_s  = n_s - prc_s;
    plast_s = ((c_s < plim_s) ? c_s : plim_s) - ONE_S;
    pdn_s   = idx_s + vc_s;
    pup_s   = idx_s - vc_s;
    hi_s    = n_s - ONE_S;
    if (put_q > hi_s) begin
      clamp_s = hi_s;
    end else if (put_q < NONE_S) begin
      clamp_s = NONE_S;
    end else begin
      clamp_s = put_q;
    end
  end

  // Scroll so that the cursor row stays inside the window, then limit to the last top row.
  always_comb begin
    top_plus_v = {1'b0, top_q} + (ROW_W + 1)'(cfg.n_vis);
    row_lo     = row_q < top_q;
    row_hi     = {1'b0, row_q} >= top_plus_v;
    row_m_v    = row_q - ROW_W'(cfg.n_vis) + ROW_W'(1);
    if (row_lo) begin
      kv_top = (row_q > hi_q) ? hi_q : row_q;
    end else if (row_hi) begin
      kv_top = (row_m_v > hi_q) ? hi_q : row_m_v;
    end else begin
      kv_top = top_q;
    end
  end

  always_comb begin
    op_put    = 1'b0;
    op_wrap2  = 1'b0;
    op_stage2 = 1'b0;
    op_tgt    = idx_s;
    case (op_q)
      OP_SET: begin
        op_put = 1'b1;
        op_tgt = ARITH_W'(tgt_q);
      end
      OP_DOWN: begin
        if (!n_zero) begin
          if (row_s < lr_s) begin
            op_put = 1'b1;
            op_tgt = idx_s + c_s;
          end else if (wrap_q && c_one) begin
            op_put = 1'b1;
            op_tgt = ZERO_S;
          end
        end
      end
      OP_UP: begin
        if (!n_zero) begin
          if (row_q != '0) begin
            op_put = 1'b1;
            op_tgt = idx_s - c_s;
          end else if (wrap_q && c_one) begin
            op_put = 1'b1;
            op_tgt = hi_s;
          end
        end
      end
      OP_RIGHT: begin
        if (!c_one) begin
          if (col_s < lastc_s) begin
            op_put = 1'b1;
            op_tgt = idx_s + ONE_S;
          end else if (wrap_q) begin
            if (!n_zero && (row_s < lr_s)) begin
              op_put    = 1'b1;
              op_stage2 = 1'b1;
              op_tgt    = idx_s + c_s;
            end else begin
              op_wrap2 = 1'b1;
            end
          end
        end
      end
      OP_LEFT: begin
        if (!c_one) begin
          if (col_q != '0) begin
            op_put = 1'b1;
            op_tgt = idx_s - ONE_S;
          end else if (wrap_q && (row_q != '0)) begin
            op_put = 1'b1;
            op_tgt = prc_s + plast_s;
          end
        end
      end
      OP_PAGE_DOWN: begin
        if (!n_zero) begin
          op_put = 1'b1;
          op_tgt = (pdn_s < n_s) ? pdn_s : hi_s;
        end
      end
      OP_PAGE_UP: begin
        if (!n_zero) begin
          op_put = 1'b1;
          op_tgt = (pup_s >= ZERO_S) ? pup_s : ZERO_S;
        end
      end
      OP_REFRESH: begin
        if (!n_zero) begin
          op_put = 1'b1;
          op_tgt = fresh ? ZERO_S : idx_s;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    div_req.start    = (state_q == ST_LR_START) || (state_q == ST_RC_START) ||
                       (state_q == ST_PRC_START);
    div_req.divisor  = cfg.n_cols;
    if (state_q == ST_LR_START) begin
      div_req.dividend = DVD_W'(cfg.n_items) + DVD_W'(cfg.n_cols) - DVD_W'(1);
    end else if (idx_q[IDX_W-1]) begin
      div_req.dividend = '0;
    end else begin
      div_req.dividend = DVD_W'(unsigned'(idx_q));
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:      if (in_valid_i) state_d = ST_LR_START;
      ST_LR_START:  state_d = ST_LR_WAIT;
      ST_LR_WAIT:   if (div_res.done) state_d = ST_RC_START;
      ST_RC_START:  state_d = ST_RC_WAIT;
      ST_RC_WAIT:   if (div_res.done) state_d = ST_OP;
      ST_OP: begin
        if (op_put) begin
          state_d = ST_PUT;
        end else if (op_wrap2) begin
          state_d = ST_WRAP2;
        end else begin
          state_d = ST_FINAL;
        end
      end
      ST_PUT:       state_d = ST_PRC_START;
      ST_PRC_START: state_d = ST_PRC_WAIT;
      ST_PRC_WAIT:  if (div_res.done) state_d = ST_PKV;
      ST_PKV:       state_d = stage2_q ? ST_WRAP2 : ST_FINAL;
      ST_WRAP2:     state_d = (idx_s < n_s) ? ST_PUT : ST_FINAL;
      ST_FINAL:     state_d = ST_DONE;
      ST_DONE:      if (out_free) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    op_d        = op_q;
    wrap_d      = wrap_q;
    tgt_d       = tgt_q;
    idx_d       = idx_q;
    top_d       = top_q;
    lwe_d       = lwe_q;
    ev_d        = ev_q;
    row_d       = row_q;
    col_d       = col_q;
    lr_d        = lr_q;
    hi_d        = hi_q;
    vc_d        = vc_q;
    put_d       = put_q;
    stage2_d    = stage2_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_idx_d   = out_idx_q;
    out_top_d   = out_top_q;
    out_row_d   = out_row_q;
    out_col_d   = out_col_q;
    out_ev_d    = out_ev_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d     = op_e'(operation_i);
          wrap_d   = wrap_i;
          tgt_d    = target_index_i;
          ev_d     = '0;
          stage2_d = 1'b0;
          vc_d     = VC_W'(cfg.n_vis) * VC_W'(cfg.n_cols);
        end
      end
      ST_LR_WAIT: begin
        if (div_res.done) begin
          lr_d = ROW_W'(div_res.quot - DVD_W'(1));
          if (!n_zero && (div_res.quot > DVD_W'(cfg.n_vis))) begin
            hi_d = ROW_W'(div_res.quot - DVD_W'(cfg.n_vis));
          end else begin
            hi_d = '0;
          end
        end
      end
      ST_RC_WAIT, ST_PRC_WAIT: begin
        if (div_res.done) begin
          row_d = ROW_W'(div_res.quot);
          col_d = div_res.rem;
        end
      end
      ST_OP: begin
        if (op_put) begin
          put_d    = op_tgt;
          stage2_d = op_stage2;
        end
        if (op_q == OP_REFRESH) begin
          if (n_zero) begin
            idx_d = IDX_NONE;
            top_d = '0;
            lwe_d = 1'b1;
            row_d = '0;
            col_d = '0;
          end else begin
            lwe_d = 1'b0;
            if (fresh) idx_d = '0;
          end
        end
      end
      ST_PUT: begin
        idx_d = IDX_W'(clamp_s);
        if (IDX_W'(clamp_s) != idx_q) ev_d = ev_q + EV_W'(1);
      end
      ST_PKV: begin
        if ((op_q == OP_REFRESH) && (kv_top > hi_q)) begin
          top_d = hi_q;
        end else begin
          top_d = kv_top;
        end
      end
      ST_WRAP2: begin
        stage2_d = 1'b0;
        put_d    = rc_s;
      end
      ST_FINAL: begin
        top_d = kv_top;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_idx_d   = OUT_IDX_W'(idx_q);
          out_top_d   = OUT_TOP_W'(top_q);
          out_row_d   = OUT_ROW_W'(row_q);
          out_col_d   = OUT_COL_W'(col_q);
          out_ev_d    = ev_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= IDX_NONE;
      top_q       <= '0;
      lwe_q       <= 1'b1;
      ev_q        <= '0;
      stage2_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      top_q       <= top_d;
      lwe_q       <= lwe_d;
      ev_q        <= ev_d;
      stage2_q    <= stage2_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    wrap_q    <= wrap_d;
    tgt_q     <= tgt_d;
    row_q     <= row_d;
    col_q     <= col_d;
    lr_q      <= lr_d;
    hi_q      <= hi_d;
    vc_q      <= vc_d;
    put_q     <= put_d;
    out_idx_q <= out_idx_d;
    out_top_q <= out_top_d;
    out_row_q <= out_row_d;
    out_col_q <= out_col_d;
    out_ev_q  <= out_ev_d;
  end

  assign out_valid_o     = out_valid_q;
  assign cursor_now_o    = out_idx_q;
  assign scroll_top_o    = out_top_q;
  assign cursor_row_o    = out_row_q;
  assign cursor_col_o    = out_col_q;
  assign select_events_o = out_ev_q;

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("block stayed ready after taking a beat");

  a_event_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> select_events_o != 2'd3)
    else $error("more than two selection changes in one step");

  a_index_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !idx_q[IDX_W-1] || idx_q == IDX_NONE)
    else $error("cursor index below minus one");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_res.done |-> state_q == ST_LR_WAIT || state_q == ST_RC_WAIT ||
                     state_q == ST_PRC_WAIT)
    else $error("divider finished outside a wait state");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE && (!out_valid_q || out_ready_i) |=> out_valid_o && in_ready_o)
    else $error("finished result not moved to the output register");
`endif

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import gmc_pkg::*;

  localparam int CYCLE_LIMIT = 1_200_000;
  localparam int RANDOM_PHASES = 13;
  localparam int BEATS_PER_PHASE = 100;
  localparam int SETTLE_CYCLES = 80;

  class cursor_scoreboard;
    typedef struct {
      logic signed [OUT_IDX_W-1:0] idx;
      logic [OUT_TOP_W-1:0]        top;
      logic [OUT_ROW_W-1:0]        row;
      logic [OUT_COL_W-1:0]        col;
      logic [EV_W-1:0]             notes;
    } cursor_view_t;

    logic [CNT_W-1:0] item_reg = '0;
    logic [COL_W-1:0] col_reg = COL_W'(1);
    logic [VIS_W-1:0] vis_reg = VIS_W'(1);
    int sel_index = -1;
    int first_row = 0;
    bit list_empty = 1'b1;
    int notify = 0;
    cursor_view_t expected_views[$];
    int errors = 0;
    int checked = 0;
    int op_count[8];

    function int eff_items();
      return (item_reg > DEF_MAX_ITEMS) ? DEF_MAX_ITEMS : int'(item_reg);
    endfunction

    function int eff_cols();
      if (col_reg == 0) return 1;
      return (col_reg > DEF_MAX_COLS) ? DEF_MAX_COLS : int'(col_reg);
    endfunction

    function int eff_rows();
      if (vis_reg == 0) return 1;
      return (vis_reg > DEF_MAX_VISIBLE) ? DEF_MAX_VISIBLE : int'(vis_reg);
    endfunction

    function int cur_row();
      return (sel_index >= 0) ? sel_index / eff_cols() : 0;
    endfunction

    function int cur_col();
      return (sel_index >= 0) ? sel_index % eff_cols() : 0;
    endfunction

    function int max_top();
      int items;
      int t;
      items = eff_items();
      if (items <= 0) return 0;
      t = (items + eff_cols() - 1) / eff_cols() - 1 - eff_rows() + 1;
      return (t < 0) ? 0 : t;
    endfunction

    function void set_top(int r);
      int hi;
      hi = max_top();
      if (r > hi) r = hi;
      if (r < 0) r = 0;
      first_row = r;
    endfunction

    function void follow_cursor();
      int row;
      row = cur_row();
      if (row < first_row) set_top(row);
      else if (row >= first_row + eff_rows()) set_top(row - eff_rows() + 1);
    endfunction

    function void select_index(int i);
      int prev;
      int hi;
      prev = sel_index;
      hi = eff_items() - 1;
      if (hi < -1) hi = -1;
      if (i > hi) i = hi;
      if (i < -1) i = -1;
      sel_index = i;
      follow_cursor();
      if (sel_index != prev) notify++;
    endfunction

    function void move_down(bit w);
      int items;
      int cols;
      items = eff_items();
      cols = eff_cols();
      if (items <= 0) return;
      if (cur_row() < (items + cols - 1) / cols - 1) select_index(sel_index + cols);
      else if (w && cols == 1) select_index(0);
    endfunction

    function void move_up(bit w);
      int items;
      items = eff_items();
      if (items <= 0) return;
      if (cur_row() > 0) select_index(sel_index - eff_cols());
      else if (w && eff_cols() == 1) select_index(items - 1);
    endfunction

    function void move_right(bit w);
      int cols;
      int lim;
      int last_col;
      cols = eff_cols();
      if (cols < 2) return;
      lim = eff_items() - cur_row() * cols;
      last_col = ((cols < lim) ? cols : lim) - 1;
      if (cur_col() < last_col) begin
        select_index(sel_index + 1);
      end else if (w) begin
        move_down(1'b0);
        if (sel_index < eff_items()) select_index(cur_row() * cols);
      end
    endfunction

    function void move_left(bit w);
      int cols;
      int prev_row;
      int lim;
      int last_col;
      cols = eff_cols();
      if (cols < 2) return;
      if (cur_col() > 0) begin
        select_index(sel_index - 1);
      end else if (w) begin
        prev_row = cur_row() - 1;
        if (prev_row >= 0) begin
          lim = eff_items() - prev_row * cols;
          last_col = ((cols < lim) ? cols : lim) - 1;
          select_index(prev_row * cols + last_col);
        end
      end
    endfunction

    function void rescan();
      if (eff_items() == 0) begin
        sel_index = -1;
        first_row = 0;
        list_empty = 1'b1;
        return;
      end
      if (list_empty && sel_index < 0) sel_index = 0;
      list_empty = 1'b0;
      select_index(sel_index);
      set_top(first_row);
    endfunction

    function void apply_reg(reg_e r, logic [DATA_W-1:0] v);
      case (r)
        REG_ITEM_COUNT:   item_reg = v[CNT_W-1:0];
        REG_COLUMN_COUNT: col_reg = v[COL_W-1:0];
        REG_VISIBLE_ROWS: vis_reg = v[VIS_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_beat(op_e op, bit w, logic signed [TGT_W-1:0] tgt);
      int items;
      int jump;
      cursor_view_t v;
      items = eff_items();
      notify = 0;
      op_count[op]++;
      case (op)
        OP_SET:   select_index(int'(tgt));
        OP_DOWN:  move_down(w);
        OP_UP:    move_up(w);
        OP_RIGHT: move_right(w);
        OP_LEFT:  move_left(w);
        OP_PAGE_DOWN: begin
          if (items > 0) begin
            jump = sel_index + eff_rows() * eff_cols();
            select_index((jump < items) ? jump : items - 1);
          end
        end
        OP_PAGE_UP: begin
          if (items > 0) begin
            jump = sel_index - eff_rows() * eff_cols();
            select_index((jump >= 0) ? jump : 0);
          end
        end
        OP_REFRESH: rescan();
        default: ;
      endcase
      follow_cursor();
      v.idx = OUT_IDX_W'(sel_index);
      v.top = OUT_TOP_W'(first_row);
      v.row = OUT_ROW_W'(cur_row());
      v.col = OUT_COL_W'(cur_col());
      v.notes = EV_W'(notify);
      expected_views = {expected_views, v};
    endfunction

    function void compare_field(string f, int want, int got, bit unknown);
      if (unknown || want != got) begin
        $display("%0t: %s expected %0d, got %0d%s", $time, f, want, got,
                 unknown ? " (unknown bits)" : "");
        errors++;
      end
    endfunction

    function void check_beat(logic signed [OUT_IDX_W-1:0] idx, logic [OUT_TOP_W-1:0] top,
                             logic [OUT_ROW_W-1:0] row, logic [OUT_COL_W-1:0] col,
                             logic [EV_W-1:0] notes);
      cursor_view_t want;
      if (expected_views.size() == 0) begin
        $display("%0t: result beat with nothing expected, cursor_now %0d", $time, idx);
        errors++;
        return;
      end
      want = expected_views.pop_front();
      checked++;
      compare_field("cursor_now", int'(want.idx), int'(idx), $isunknown(idx));
      compare_field("scroll_top", int'(want.top), int'(top), $isunknown(top));
      compare_field("cursor_row", int'(want.row), int'(row), $isunknown(row));
      compare_field("cursor_col", int'(want.col), int'(col), $isunknown(col));
      compare_field("select_events", int'(want.notes), int'(notes), $isunknown(notes));
    endfunction

    function int pending();
      return expected_views.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;
  logic in_valid_i;
  logic in_ready_o;
  logic [OP_W-1:0] operation_i;
  logic wrap_i;
  logic signed [TGT_W-1:0] target_index_i;
  logic out_valid_o;
  logic out_ready_i;
  logic signed [OUT_IDX_W-1:0] cursor_now_o;
  logic [OUT_TOP_W-1:0] scroll_top_o;
  logic [OUT_ROW_W-1:0] cursor_row_o;
  logic [OUT_COL_W-1:0] cursor_col_o;
  logic [EV_W-1:0] select_events_o;

  cursor_scoreboard sb = new;
  bit steady = 1'b0;
  bit valid_held = 1'b0;
  int gap_ahead = 0;
  int settings = 0;
  int cycle_count = 0;

  grid_menu_cursor u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .operation_i     (operation_i),
    .wrap_i          (wrap_i),
    .target_index_i  (target_index_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .cursor_now_o    (cursor_now_o),
    .scroll_top_o    (scroll_top_o),
    .cursor_row_o    (cursor_row_o),
    .cursor_col_o    (cursor_col_o),
    .select_events_o (select_events_o)
  );

  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle_count, sb.pending());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_beat(cursor_now_o, scroll_top_o, cursor_row_o, cursor_col_o, select_events_o);
    end
  end

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  initial begin
    int n;
    out_ready_i = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      n = pick_gap();
      if (n > 0) begin
        out_ready_i <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  task automatic send_item(op_e op, bit w, logic signed [TGT_W-1:0] tgt);
    repeat (gap_ahead) @(posedge clk_i);
    in_valid_i <= 1'b1;
    operation_i <= op;
    wrap_i <= w;
    target_index_i <= tgt;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_beat(op, w, tgt);
    gap_ahead = pick_gap();
    valid_held = (gap_ahead == 0);
    if (gap_ahead > 0) in_valid_i <= 1'b0;
  endtask

  task automatic drain_results();
    if (valid_held) begin
      in_valid_i <= 1'b0;
      valid_held = 1'b0;
      @(posedge clk_i);
    end
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic apb_write(reg_e r, logic [DATA_W-1:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.apply_reg(r, v);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic configure(int items, int cols, int rows);
    drain_results();
    apb_write(REG_ITEM_COUNT, items);
    apb_write(REG_COLUMN_COUNT, cols);
    apb_write(REG_VISIBLE_ROWS, rows);
    settings++;
  endtask

  task automatic run_directed();
    configure(0, 1, 1);
    send_item(OP_DOWN, 1'b1, 0);
    send_item(OP_UP, 1'b1, 0);
    send_item(OP_PAGE_DOWN, 1'b0, 0);
    send_item(OP_SET, 1'b0, 5);
    send_item(OP_REFRESH, 1'b0, 0);
    configure(10, 3, 2);
    send_item(OP_REFRESH, 1'b0, 0);
    send_item(OP_SET, 1'b0, 255);
    send_item(OP_RIGHT, 1'b1, 0);
    send_item(OP_SET, 1'b0, -256);
    send_item(OP_DOWN, 1'b0, 0);
    send_item(OP_LEFT, 1'b1, 0);
    send_item(OP_RIGHT, 1'b1, 0);
    send_item(OP_RIGHT, 1'b1, 0);
    send_item(OP_LEFT, 1'b1, 0);
    send_item(OP_PAGE_DOWN, 1'b0, 0);
    send_item(OP_PAGE_UP, 1'b0, 0);
    send_item(OP_UP, 1'b1, 0);
    send_item(OP_LEFT, 1'b0, 0);
    configure(511, 1, 127);
    send_item(OP_REFRESH, 1'b0, 0);
    send_item(OP_UP, 1'b1, 0);
    send_item(OP_DOWN, 1'b1, 0);
    send_item(OP_RIGHT, 1'b1, 0);
    configure(511, 31, 127);
    send_item(OP_PAGE_DOWN, 1'b0, 0);
    send_item(OP_SET, 1'b0, -1);
    send_item(OP_LEFT, 1'b1, 0);
  endtask

  function automatic int pick_items();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 1;
      2: return DEF_MAX_ITEMS;
      3: return $urandom_range(DEF_MAX_ITEMS + 1, 511);
      4, 5, 6: return $urandom_range(2, 40);
      default: return $urandom_range(0, 511);
    endcase
  endfunction

  function automatic int pick_cols();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 1;
      2: return DEF_MAX_COLS;
      3: return $urandom_range(DEF_MAX_COLS + 1, 31);
      default: return $urandom_range(2, 8);
    endcase
  endfunction

  function automatic int pick_rows();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 1;
      2: return DEF_MAX_VISIBLE;
      3: return $urandom_range(DEF_MAX_VISIBLE + 1, 127);
      default: return $urandom_range(1, 12);
    endcase
  endfunction

  task automatic send_random_beat();
    int r;
    op_e op;
    logic signed [TGT_W-1:0] tgt;
    r = $urandom_range(0, 99);
    if (r < 14) op = OP_SET;
    else if (r < 30) op = OP_DOWN;
    else if (r < 46) op = OP_UP;
    else if (r < 62) op = OP_RIGHT;
    else if (r < 78) op = OP_LEFT;
    else if (r < 86) op = OP_PAGE_DOWN;
    else if (r < 94) op = OP_PAGE_UP;
    else op = OP_REFRESH;
    if ($urandom_range(0, 9) < 7) tgt = TGT_W'($urandom_range(0, sb.eff_items()) - 1);
    else tgt = TGT_W'($urandom);
    send_item(op, 1'($urandom_range(0, 1)), tgt);
  endtask

  task automatic random_phase();
    configure(pick_items(), pick_cols(), pick_rows());
    steady = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 9) < 7) begin
      send_item(OP_REFRESH, 1'($urandom_range(0, 1)), TGT_W'($urandom));
    end
    for (int k = 0; k < BEATS_PER_PHASE; k++) begin
      if (k == BEATS_PER_PHASE / 2 && $urandom_range(0, 2) == 0) drain_results();
      send_random_beat();
    end
    steady = 1'b0;
  endtask

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid_i = 1'b0;
    operation_i = OP_SET;
    wrap_i = 1'b0;
    target_index_i = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    run_directed();
    for (int p = 0; p < RANDOM_PHASES; p++) random_phase();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Checked %0d result beats over %0d register settings.", sb.checked, settings);
    $display("Ops set/down/up/right/left/pgdn/pgup/refresh: %0d %0d %0d %0d %0d %0d %0d %0d",
             sb.op_count[OP_SET], sb.op_count[OP_DOWN], sb.op_count[OP_UP],
             sb.op_count[OP_RIGHT], sb.op_count[OP_LEFT], sb.op_count[OP_PAGE_DOWN],
             sb.op_count[OP_PAGE_UP], sb.op_count[OP_REFRESH]);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== grid_menu_cursor.f =====
sv/gmc_pkg.sv
sv/gmc_regs.sv
sv/gmc_div.sv
sv/grid_menu_cursor.sv
tb/sv/tb_top.sv
